// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bamc_pkg.sv =====
// ----------------------------------------------------------------------------
// bamc_pkg
// Types and constants for the button autorepeat and mode cycler.
// ----------------------------------------------------------------------------
package bamc_pkg;

   localparam int NUM_MODES = 5;
   localparam int MODE_W    = 3;
   localparam int TIMER_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_COUNT = 2'd2;

   localparam logic [TIMER_W-1:0] SLOW_PERIOD_RST = 8'd150;
   localparam logic [TIMER_W-1:0] FAST_PERIOD_RST = 8'd75;
   localparam logic [TIMER_W-1:0] ACCEL_COUNT_RST = 8'd5;
   localparam logic [TIMER_W-1:0] RELEASE_LOAD    = 8'd1;

   localparam logic [MODE_W-1:0] MODE_RUN = 3'd0;

   typedef struct packed {
      logic mode_pressed;
      logic lower_pressed;
      logic upper_pressed;
   } req_type;

   typedef struct packed {
      logic [MODE_W-1:0] current_mode;
      logic              mode_changed;
      logic              lower_fire;
      logic              upper_fire;
      logic              clock_stop;
   } rsp_type;

   typedef struct packed {
      logic [TIMER_W-1:0] slow_period;
      logic [TIMER_W-1:0] fast_period;
      logic [TIMER_W-1:0] accel_count;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode_reg;
      logic [TIMER_W-1:0] mode_countdown;
      logic [TIMER_W-1:0] lower_countdown;
      logic [TIMER_W-1:0] upper_countdown;
      logic [TIMER_W-1:0] repeat_tally;
   } state_type;

endpackage

// ===== hdl/bamc_step.sv =====
// ----------------------------------------------------------------------------
// bamc_step
// One tick of the mode cycler and the two autorepeat timers.
// ----------------------------------------------------------------------------
module bamc_step (
   input  bamc_pkg::req_type   req,
   input  bamc_pkg::cfg_type   cfg,
   input  bamc_pkg::state_type cur,
   output bamc_pkg::state_type nxt,
   output bamc_pkg::rsp_type   rsp
);
   import bamc_pkg::*;

   always_comb begin
      logic [MODE_W:0] mode_inc;
      logic            lfire;
      logic            ufire;
      logic            changed;
      nxt     = cur;
      lfire   = 1'b0;
      ufire   = 1'b0;
      changed = 1'b0;
      mode_inc = {1'b0, cur.mode_reg} + {{MODE_W{1'b0}}, 1'b1};

      if (req.mode_pressed) begin
         nxt.mode_countdown = cur.mode_countdown - TIMER_W'(1);
         if (nxt.mode_countdown == '0) begin
            nxt.mode_countdown = cfg.slow_period;
            nxt.mode_reg = (mode_inc >= (MODE_W+1)'(NUM_MODES)) ? MODE_RUN
                                                                : mode_inc[MODE_W-1:0];
            changed = 1'b1;
         end
      end

      // run mode leaves the repeat timers alone, based on the advanced mode
      if (nxt.mode_reg != MODE_RUN) begin
         if (req.lower_pressed) begin
            nxt.lower_countdown = cur.lower_countdown - TIMER_W'(1);
            if (nxt.lower_countdown == '0) begin
               lfire = 1'b1;
               if (cur.repeat_tally < cfg.accel_count) begin
                  nxt.repeat_tally    = cur.repeat_tally + TIMER_W'(1);
                  nxt.lower_countdown = cfg.slow_period;
               end else begin
                  nxt.lower_countdown = cfg.fast_period;
               end
            end
         end else begin
            nxt.repeat_tally    = '0;
            nxt.lower_countdown = RELEASE_LOAD;
         end

         if (req.upper_pressed) begin
            nxt.upper_countdown = cur.upper_countdown - TIMER_W'(1);
            if (nxt.upper_countdown == '0) begin
               ufire = 1'b1;
               nxt.upper_countdown = cfg.slow_period;
            end
         end else begin
            nxt.upper_countdown = RELEASE_LOAD;
         end
      end

      rsp.current_mode = nxt.mode_reg;
      rsp.mode_changed = changed;
      rsp.lower_fire   = lfire;
      rsp.upper_fire   = ufire;
      rsp.clock_stop   = lfire | ufire;
   end

endmodule

// ===== hdl/button_autorepeat_mode_cycler.sv =====
// an accepted item waits in the input register and its result is registered on rsp_data
//    once the output register is free, that is rsp_valid low or rsp_stall low
// throughput: one item per cycle unless a stall holds it; the state update is a single
//    pass of decrement, compare and reload between the input and result registers
// reset: synchronous; registers return to 150/75/5, mode 0, all timers 0
// ----------------------------------------------------------------------------
// button_autorepeat_mode_cycler
// Button autorepeat with acceleration and a five-way mode cycler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_autorepeat_mode_cycler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bamc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bamc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bamc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bamc_pkg::TIMER_W-1:0]        csr_wdata
);
   import bamc_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_nxt;
   rsp_type   step_rsp;
   logic      advance;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = accept || (in_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLOW_PERIOD: cfg_in.slow_period = csr_wdata;
            CSR_FAST_PERIOD: cfg_in.fast_period = csr_wdata;
            CSR_ACCEL_COUNT: cfg_in.accel_count = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   bamc_step u_step (
      .req (in_data_ff),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_nxt),
      .rsp (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{SLOW_PERIOD_RST, FAST_PERIOD_RST, ACCEL_COUNT_RST};
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_SAME(a_mode_range, clock, reset, 1'b1, {1'b0, state_ff.mode_reg} < (MODE_W+1)'(NUM_MODES), "mode out of range")
   `ASSERT_SAME(a_fire_not_run, clock, reset, rsp_valid && (rsp_data.lower_fire || rsp_data.upper_fire), rsp_data.current_mode != MODE_RUN, "fire in run mode")
   `ASSERT_NEXT(a_mode_reload, clock, reset, advance && step_rsp.mode_changed, state_ff.mode_countdown == $past(cfg_ff.slow_period), "mode timer not reloaded")
   `ASSERT_SAME(a_no_overwrite, clock, reset, accept && in_valid_ff, advance, "input register overwritten")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the button autorepeat and mode cycler.
// Drives button samples through the req channel with random gaps, applies
// random stalls on the rsp channel, and checks every result against an
// in-bench model of the timers, repeat tally and mode. Register settings
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bamc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 17;
   localparam int RANDOM_TICKS = 720;
   localparam int PHASES       = 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIMER_W-1:0]   csr_wdata;

   // model copy of the registers and of the block state
   cfg_type   regs;
   state_type btn_state;
   rsp_type   pending_outputs[$];

   bit steady      = 1'b0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int errors      = 0;
   int ticks_sent  = 0;
   int results_seen = 0;
   int lower_fires = 0;
   int upper_fires = 0;
   int mode_steps  = 0;
   int settings    = 0;

   button_autorepeat_mode_cycler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one tick of button sampling, updates the model state
   function automatic rsp_type autorepeat_tick(input req_type t);
      rsp_type         r;
      logic [MODE_W:0] nxt;
      r = '0;
      if (t.mode_pressed) begin
         btn_state.mode_countdown = btn_state.mode_countdown - 1'b1;
         if (btn_state.mode_countdown == '0) begin
            nxt = {1'b0, btn_state.mode_reg} + 1'b1;
            btn_state.mode_countdown = regs.slow_period;
            btn_state.mode_reg = (nxt >= NUM_MODES) ? MODE_RUN : nxt[MODE_W-1:0];
            r.mode_changed = 1'b1;
         end
      end
      // run mode leaves the repeat timers alone, release included
      if (btn_state.mode_reg != MODE_RUN) begin
         if (t.lower_pressed) begin
            btn_state.lower_countdown = btn_state.lower_countdown - 1'b1;
            if (btn_state.lower_countdown == '0) begin
               r.lower_fire = 1'b1;
               if (btn_state.repeat_tally < regs.accel_count) begin
                  btn_state.repeat_tally = btn_state.repeat_tally + 1'b1;
                  btn_state.lower_countdown = regs.slow_period;
               end else begin
                  btn_state.lower_countdown = regs.fast_period;
               end
            end
         end else begin
            btn_state.repeat_tally = '0;
            btn_state.lower_countdown = RELEASE_LOAD;
         end
         if (t.upper_pressed) begin
            btn_state.upper_countdown = btn_state.upper_countdown - 1'b1;
            if (btn_state.upper_countdown == '0) begin
               r.upper_fire = 1'b1;
               btn_state.upper_countdown = regs.slow_period;
            end
         end else begin
            btn_state.upper_countdown = RELEASE_LOAD;
         end
      end
      r.current_mode = btn_state.mode_reg;
      r.clock_stop   = r.lower_fire | r.upper_fire;
      return r;
   endfunction

   function automatic req_type press(input bit m, input bit l, input bit u);
      req_type t;
      t.mode_pressed  = m;
      t.lower_pressed = l;
      t.upper_pressed = u;
      return t;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            $error("result with no item pending: %p", rsp_data);
            errors++;
         end else begin
            want = pending_outputs.pop_front();
            check_field("current_mode", 8'(want.current_mode), 8'(rsp_data.current_mode));
            check_field("mode_changed", 8'(want.mode_changed), 8'(rsp_data.mode_changed));
            check_field("lower_fire", 8'(want.lower_fire), 8'(rsp_data.lower_fire));
            check_field("upper_fire", 8'(want.upper_fire), 8'(rsp_data.upper_fire));
            check_field("clock_stop", 8'(want.clock_stop), 8'(rsp_data.clock_stop));
            results_seen++;
            lower_fires += int'(want.lower_fire);
            upper_fires += int'(want.upper_fire);
            mode_steps  += int'(want.mode_changed);
         end
      end
   end

   // receiver: random stalls, or a long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic send_tick(input req_type t);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outputs.push_back(autorepeat_tick(t));
      ticks_sent++;
   endtask

   task automatic hold_buttons(input req_type t, input int n);
      repeat (n) send_tick(t);
   endtask

   // hold mode alone until the model reaches the wanted mode
   task automatic goto_mode(input logic [MODE_W-1:0] m);
      while (btn_state.mode_reg != m) send_tick(press(1'b1, 1'b0, 1'b0));
   endtask

   // stop sending and wait for every pending result
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_valid high, the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIMER_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SLOW_PERIOD: regs.slow_period = value;
         CSR_FAST_PERIOD: regs.fast_period = value;
         CSR_ACCEL_COUNT: regs.accel_count = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [TIMER_W-1:0] slow, input logic [TIMER_W-1:0] fast,
                            input logic [TIMER_W-1:0] accel);
      settle();
      write_reg(CSR_SLOW_PERIOD, slow);
      write_reg(CSR_FAST_PERIOD, fast);
      write_reg(CSR_ACCEL_COUNT, accel);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // every button combination in run mode, nothing may fire
   task automatic test_run_mode();
      for (int v = 0; v < 8; v++) send_tick(req_type'(v[2:0]));
   endtask

   // timers start at zero, so the first mode step takes 256 held ticks
   task automatic test_first_press();
      goto_mode(3'd1);
      hold_buttons(press(1'b1, 1'b1, 1'b1), 152);
      hold_buttons(press(1'b0, 1'b0, 1'b0), 2);
   endtask

   task automatic test_mode_wrap();
      configure(8'd1, FAST_PERIOD_RST, ACCEL_COUNT_RST);
      goto_mode(MODE_RUN);
      // one step per tick now, passes through 4 -> 0 with the repeat buttons held
      hold_buttons(press(1'b1, 1'b1, 1'b1), 7);
      hold_buttons(press(1'b0, 1'b1, 1'b0), 3);
   endtask

   task automatic test_acceleration();
      configure(8'd4, 8'd2, 8'd3);
      goto_mode(3'd1);
      hold_buttons(press(1'b0, 1'b1, 1'b0), 30);
      hold_buttons(press(1'b0, 1'b0, 1'b0), 2);
      hold_buttons(press(1'b0, 1'b1, 1'b0), 12);
      // no slow repeats at all
      configure(8'd4, 8'd1, 8'd0);
      hold_buttons(press(1'b0, 1'b0, 1'b0), 1);
      hold_buttons(press(1'b0, 1'b1, 1'b0), 6);
      configure(8'd1, 8'd1, 8'd0);
      hold_buttons(press(1'b0, 1'b1, 1'b1), 5);
   endtask

   task automatic test_register_extremes();
      goto_mode(3'd2);
      // a zero reload wraps to 255 on the next held tick
      configure(8'd0, 8'd255, 8'd0);
      hold_buttons(press(1'b0, 1'b0, 1'b0), 1);
      hold_buttons(press(1'b0, 1'b1, 1'b1), 258);
      configure(8'd255, 8'd255, 8'd255);
      hold_buttons(press(1'b0, 1'b0, 1'b0), 1);
      hold_buttons(press(1'b1, 1'b1, 1'b1), 4);
   endtask

   task automatic test_unknown_index();
      settle();
      write_reg(CSR_UNUSED, 8'hA5);
      csr_valid <= 1'b0;
      hold_buttons(press(1'b0, 1'b0, 1'b0), 1);
      hold_buttons(press(1'b0, 1'b1, 1'b1), 5);
      configure(8'd2, 8'd1, 8'd2);
      hold_buttons(press(1'b0, 1'b1, 1'b0), 10);
   endtask

   // receiver holds off while items keep coming, input must stall
   task automatic test_backpressure();
      steady = 1'b1;
      hold_cycles = 120;
      for (int k = 0; k < 80; k++) send_tick(req_type'(3'($urandom_range(7))));
      steady = 1'b0;
      settle();
   endtask

   task automatic test_random();
      req_type          lvl;
      req_type          t;
      logic [TIMER_W-1:0] slow;
      logic [TIMER_W-1:0] fast;
      logic [TIMER_W-1:0] accel;
      lvl = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(9))
            0: slow = 8'd0;
            1: slow = 8'd255;
            2: slow = 8'($urandom_range(255));
            default: slow = 8'($urandom_range(1, 8));
         endcase
         case ($urandom_range(9))
            0: fast = 8'd0;
            1: fast = 8'd255;
            default: fast = 8'($urandom_range(1, 6));
         endcase
         accel = ($urandom_range(9) == 0) ? 8'd255 : 8'($urandom_range(6));
         configure(slow, fast, accel);
         steady = (phase == 2);
         // get out of run mode quickly when the mode timer allows it
         if (btn_state.mode_countdown != '0 && btn_state.mode_countdown <= 16 &&
             regs.slow_period != '0 && regs.slow_period <= 16)
            goto_mode(MODE_W'($urandom_range(1, NUM_MODES - 1)));
         for (int k = 0; k < RANDOM_TICKS / PHASES; k++) begin
            if (phase == 5 && k == 40) hold_cycles = 150;
            if (phase == 6 && k == 40) settle();
            if ($urandom_range(99) < 15) begin
               t = req_type'(3'($urandom_range(7)));
            end else begin
               // held buttons with occasional presses and releases
               if ($urandom_range(99) < (lvl.mode_pressed ? 15 : 3))
                  lvl.mode_pressed = !lvl.mode_pressed;
               if ($urandom_range(11) == 0) lvl.lower_pressed = !lvl.lower_pressed;
               if ($urandom_range(11) == 0) lvl.upper_pressed = !lvl.upper_pressed;
               t = lvl;
            end
            send_tick(t);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SLOW_PERIOD;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      regs = '{SLOW_PERIOD_RST, FAST_PERIOD_RST, ACCEL_COUNT_RST};
      btn_state = '0;

      test_run_mode();
      test_first_press();
      test_mode_wrap();
      test_acceleration();
      test_register_extremes();
      test_unknown_index();
      test_backpressure();
      test_random();

      settle();
      repeat (10) @(posedge clock);
      $display("ran %0d button ticks under %0d register settings, %0d results checked",
               ticks_sent, settings, results_seen);
      $display("saw %0d mode steps, %0d lower repeats and %0d upper repeats",
               mode_steps, lower_fires, upper_fires);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bamc_pkg.sv
hdl/bamc_step.sv
hdl/button_autorepeat_mode_cycler.sv
bench/tb.sv
